// File: rtl/core/hermite_cubic_resampler_top_defines.svh
// ----------------------------------------------------------------------------
// Hermite cubic resampler assertion macros
// Shorthand for the concurrent checks on the resampler's ports. The macros
// expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef HERMITE_CUBIC_RESAMPLER_TOP_DEFINES_SVH
`define HERMITE_CUBIC_RESAMPLER_TOP_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define HCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define HCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler package
// Shared widths, payload types and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int STEP_WIDTH    = 19;
  localparam int QUEUE_DEPTH   = 2;
  localparam int WINDOW_TAPS   = 4;

  localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(65536);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Interpolation bases that one input sample can release, in order.
  typedef enum logic [1:0] {
    JOB_CUR,
    JOB_NEXT,
    JOB_END
  } job_t;

  typedef struct packed {
    sample_t in_sample;
    logic    in_last;
  } in_item_t;

  typedef struct packed {
    sample_t out_sample;
    logic    run_last;
  } out_item_t;

  // Window of the first base to run; later bases shift in win[3] again.
  typedef struct packed {
    sample_t [WINDOW_TAPS-1:0] win;
    job_t                      first_job;
    logic                      flush;
  } queue_entry_t;

endpackage

// File: rtl/core/hcr_front.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler front end
// Accepts samples, keeps the four-sample window and works out which
// interpolation bases each sample releases.
// ----------------------------------------------------------------------------
module hcr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hcr_pkg::in_item_t     in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output hcr_pkg::queue_entry_t q_entry
);

  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic [1:0]                                    seen_r;
  hcr_pkg::sample_t [hcr_pkg::WINDOW_TAPS-1:0]   win_r;
  hcr_pkg::sample_t [hcr_pkg::WINDOW_TAPS-1:0]   win_upd_w;
  hcr_pkg::sample_t [hcr_pkg::WINDOW_TAPS-1:0]   win_adv_w;
  hcr_pkg::sample_t                              v_w;
  logic [1:0]                                    seen_inc_w;
  logic                                          accept_w;
  logic                                          last_w;
  logic                                          job0_w;
  logic                                          job1_w;

  assign v_w      = in_data.in_sample;
  assign last_w   = in_data.in_last;
  assign in_stall = q_full;
  assign accept_w = in_valid && !q_full;

  // The first sample of a buffer fills the whole window, so the sample
  // before the start reads as the first one.
  always_comb begin
    win_upd_w[hcr_pkg::WINDOW_TAPS-1] = v_w;
    for (int i = 0; i < hcr_pkg::WINDOW_TAPS - 1; i++) begin
      win_upd_w[i] = (seen_r == 2'd0) ? v_w : win_r[i+1];
    end
    for (int i = 0; i < hcr_pkg::WINDOW_TAPS - 1; i++) begin
      win_adv_w[i] = win_upd_w[i+1];
    end
    win_adv_w[hcr_pkg::WINDOW_TAPS-1] = v_w;
  end

  assign seen_inc_w = (seen_r == SEEN_FULL) ? SEEN_FULL : seen_r + 2'd1;
  assign job0_w     = (seen_inc_w == SEEN_FULL);
  assign job1_w     = last_w && seen_inc_w[1];

  always_comb begin
    q_entry.flush = last_w;
    if (job0_w) begin
      q_entry.win       = win_upd_w;
      q_entry.first_job = hcr_pkg::JOB_CUR;
    end else begin
      // Past the end the window repeats the last sample, so one shift covers
      // both flush bases when the buffer is short.
      q_entry.win       = win_adv_w;
      q_entry.first_job = job1_w ? hcr_pkg::JOB_NEXT : hcr_pkg::JOB_END;
    end
  end

  assign q_push = accept_w && (job0_w || last_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (accept_w) begin
      seen_r <= last_w ? 2'd0 : seen_inc_w;
      win_r  <= win_upd_w;
    end
  end

endmodule

// File: rtl/core/hcr_queue.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler job queue
// Short first-in first-out queue of base jobs between the front and back end.
// ----------------------------------------------------------------------------
module hcr_queue #(
  parameter int DEPTH = hcr_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hcr_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output hcr_pkg::queue_entry_t head,
  output logic                  empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  hcr_pkg::queue_entry_t mem_r [DEPTH];
  logic [AW-1:0]         wr_ptr_r;
  logic [AW-1:0]         rd_ptr_r;
  logic [CNTW-1:0]       count_r;
  logic                  do_push_w;
  logic                  do_pop_w;

  assign full      = (count_r == CNTW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push_w = push && !full;
  assign do_pop_w  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push_w) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push_w) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop_w) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push_w, do_pop_w})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/hcr_back.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler back end
// Walks the output positions of each queued base and evaluates the cubic by
// Horner's rule on one shared multiplier.
// ----------------------------------------------------------------------------
module hcr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hcr_pkg::STEP_WIDTH-1:0] step_rate,
  input  logic                           q_empty,
  input  hcr_pkg::queue_entry_t          q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hcr_pkg::out_item_t             out_data
);

  localparam int FRAC_BITS = hcr_pkg::FRAC_BITS_DEF;
  localparam int SW    = hcr_pkg::SAMPLE_WIDTH;
  localparam int CW    = SW + 4;
  localparam int ACC_W = SW + FRAC_BITS + 5;
  localparam int PW    = ACC_W + FRAC_BITS;
  localparam int POS_W = FRAC_BITS + 3;
  localparam int QW    = ACC_W - FRAC_BITS - 1;
  localparam int SCW   = (POS_W > hcr_pkg::STEP_WIDTH) ? POS_W : hcr_pkg::STEP_WIDTH;

  localparam logic [POS_W-1:0] ONE      = POS_W'(1) << FRAC_BITS;
  localparam logic [SCW-1:0]   STEP_LO  = SCW'(1) << (FRAC_BITS - 4);
  localparam logic [SCW-1:0]   STEP_HI  = SCW'(4) << FRAC_BITS;
  localparam logic [QW-1:0]    QMAX_POS = {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [QW-1:0]    QMAX_NEG = {{(QW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
  localparam hcr_pkg::sample_t SMAX     = {1'b0, {(SW-1){1'b1}}};
  localparam hcr_pkg::sample_t SMIN     = {1'b1, {(SW-1){1'b0}}};
  localparam logic [1:0]       HORNER_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ADD,
    ST_OUT,
    ST_NEXT
  } state_t;

  state_t                                      state_r;
  hcr_pkg::sample_t [hcr_pkg::WINDOW_TAPS-1:0] win_r;
  hcr_pkg::job_t                               job_r;
  logic                                        flush_r;
  logic [POS_W-1:0]                            pos_r;
  logic signed [CW-1:0]                        c1_r;
  logic signed [CW-1:0]                        c2_r;
  logic signed [CW-1:0]                        c3_r;
  logic signed [ACC_W-1:0]                     acc_r;
  logic [ACC_W-1:0]                            prod_r;
  logic                                        neg_r;
  logic [1:0]                                  k_r;
  logic                                        out_valid_r;
  hcr_pkg::out_item_t                          out_data_r;

  logic signed [CW-1:0]    x0_w, x1_w, x2_w, x3_w, d12_w;
  logic signed [CW-1:0]    c1_w, c2_w, c3_w, coef_w;
  logic signed [ACC_W-1:0] coef_ext_w, term_w, acc_add_w;
  logic [ACC_W-1:0]        mag_w;
  logic [PW-1:0]           prod_full_w;
  logic [QW-1:0]           q_w;
  hcr_pkg::sample_t        res_w;
  logic [SCW-1:0]          step_ext_w, step_cl_w;
  logic [POS_W-1:0]        step_w, pos_sum_w, thresh_w;
  logic [1:0]              rem_w;
  logic                    last_out_w;
  logic                    last_job_w;
  logic                    out_free_w;
  hcr_pkg::job_t           job_next_w;

  assign x0_w  = CW'($signed(win_r[0]));
  assign x1_w  = CW'($signed(win_r[1]));
  assign x2_w  = CW'($signed(win_r[2]));
  assign x3_w  = CW'($signed(win_r[3]));
  assign d12_w = x1_w - x2_w;
  assign c1_w  = x2_w - x0_w;
  assign c2_w  = (x0_w <<< 1) - ((x1_w <<< 2) + x1_w) + (x2_w <<< 2) - x3_w;
  assign c3_w  = (x3_w - x0_w) + d12_w + (d12_w <<< 1);

  assign step_ext_w = SCW'(step_rate);
  assign step_cl_w  = (step_ext_w < STEP_LO) ? STEP_LO :
                      (step_ext_w > STEP_HI) ? STEP_HI : step_ext_w;
  assign step_w     = step_cl_w[POS_W-1:0];

  // Sign and magnitude around the multiplier gives truncation toward zero.
  assign mag_w       = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign prod_full_w = PW'(mag_w) * PW'(pos_r[FRAC_BITS-1:0]);

  always_comb begin
    case (k_r)
      2'd0:    coef_w = c2_r;
      2'd1:    coef_w = c1_r;
      default: coef_w = x1_w <<< 1;
    endcase
  end

  assign coef_ext_w = ACC_W'(coef_w);
  assign term_w     = neg_r ? -$signed(prod_r) : $signed(prod_r);
  assign acc_add_w  = (coef_ext_w <<< FRAC_BITS) + term_w;

  // The accumulator holds twice the result, hence the extra bit of shift.
  assign q_w = mag_w[ACC_W-1:FRAC_BITS+1];
  always_comb begin
    if (!acc_r[ACC_W-1]) begin
      res_w = (q_w > QMAX_POS) ? SMAX : q_w[SW-1:0];
    end else begin
      res_w = (q_w > QMAX_NEG) ? SMIN : -q_w[SW-1:0];
    end
  end

  // A result closes its input's run when none of the remaining bases of the
  // same entry reaches a position below one.
  always_comb begin
    rem_w = 2'd0;
    if (flush_r) begin
      case (job_r)
        hcr_pkg::JOB_CUR:  rem_w = 2'd2;
        hcr_pkg::JOB_NEXT: rem_w = 2'd1;
        default:           rem_w = 2'd0;
      endcase
    end
  end

  always_comb begin
    case (job_r)
      hcr_pkg::JOB_CUR:  job_next_w = hcr_pkg::JOB_NEXT;
      default:           job_next_w = hcr_pkg::JOB_END;
    endcase
  end

  assign pos_sum_w  = pos_r + step_w;
  assign thresh_w   = POS_W'({1'b0, rem_w} + 3'd1) << FRAC_BITS;
  assign last_out_w = (pos_sum_w >= thresh_w);
  assign last_job_w = !flush_r || (job_r == hcr_pkg::JOB_END);
  assign out_free_w = !out_valid_r || !out_stall;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_OUT) && out_free_w) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            win_r   <= q_head.win;
            job_r   <= q_head.first_job;
            flush_r <= q_head.flush;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (pos_r < ONE) begin
            c1_r    <= c1_w;
            c2_r    <= c2_w;
            c3_r    <= c3_w;
            acc_r   <= (ACC_W'(c3_w)) <<< FRAC_BITS;
            k_r     <= 2'd0;
            state_r <= ST_MUL;
          end else begin
            pos_r   <= pos_r - ONE;
            state_r <= ST_NEXT;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_full_w[PW-1:FRAC_BITS];
          neg_r   <= acc_r[ACC_W-1];
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          acc_r <= acc_add_w;
          if (k_r == HORNER_LAST) begin
            state_r <= ST_OUT;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_free_w) begin
            out_data_r.out_sample <= res_w;
            out_data_r.run_last   <= last_out_w;
            if (pos_sum_w < ONE) begin
              pos_r   <= pos_sum_w;
              acc_r   <= (ACC_W'(c3_r)) <<< FRAC_BITS;
              k_r     <= 2'd0;
              state_r <= ST_MUL;
            end else begin
              pos_r   <= pos_sum_w - ONE;
              state_r <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          if (last_job_w) begin
            if (flush_r) begin
              pos_r <= '0;
            end
            state_r <= ST_IDLE;
          end else begin
            job_r    <= job_next_w;
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2] <= win_r[3];
            state_r  <= ST_SETUP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/hermite_cubic_resampler_top.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler
// Streaming 4-point, 3rd-order Hermite resampler with a fixed-point position.
// ----------------------------------------------------------------------------
// Signed samples enter one transaction at a time on the in_ channel, with
// in_last marking the final sample of a buffer, and resampled values leave on
// the out_ channel at positions 0, step, 2*step and so on, each interpolated
// from the four samples around its position and truncated toward zero and
// saturated to the sample width. The step is a 19-bit unsigned value with
// 16 fraction bits, to be written by the user through cfg_we and cfg_wdata
// while the block is idle, which the block itself does not enforce, clamped
// internally to the range 1/16 to 4, and 1.0 after reset. A result is
// released once the sample two places beyond its base has arrived, so the
// first results of a buffer follow its third sample; the last sample flushes
// the remaining positions, with out_data.run_last marking the final result
// that each input transaction causes, and the next sample then starts a new
// buffer. Samples before the start and past the end read as the first and
// last sample. An input transaction may cause no result at all, and at most
// 48. The front end takes an input transaction in every cycle until its job
// queue of QUEUE_DEPTH entries is full; the back end drains that queue on a
// single shared multiplier, taking the next entry only once done with the
// current one: it reads an entry when idle, sets up and steps past each base,
// and makes each result in three Horner steps of a multiply and an add, then
// an output step. A result waiting in the output register stalls the back
// end only when the next result is ready.
// ----------------------------------------------------------------------------
module hermite_cubic_resampler_top #(
  parameter int QUEUE_DEPTH = hcr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hcr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hcr_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [hcr_pkg::STEP_WIDTH-1:0] cfg_wdata
);

  // The step register is the only configuration; clamping happens in the
  // back end so that the stored value is exactly what was written.
  logic [hcr_pkg::STEP_WIDTH-1:0] step_rate_r;

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  hcr_pkg::queue_entry_t q_entry;
  hcr_pkg::queue_entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_rate_r <= hcr_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_rate_r <= cfg_wdata;
    end
  end

  // The front end keeps the sample window and turns each input transaction
  // that releases a base into one queue entry naming the bases it releases.
  hcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  hcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // The back end owns the position and produces every result.
  hcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_rate (step_rate_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/hcr_checker.sv
// ----------------------------------------------------------------------------
// Hermite cubic resampler port checker
// Concurrent checks on the resampler's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "hermite_cubic_resampler_top_defines.svh"

module hcr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hcr_pkg::out_item_t out_data
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  `HCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `HCR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  // The queue can only fill up through an accepted input transaction.
  `HCR_ASSERT_SAME(a_stall_rise, $rose(in_stall), $past(in_acc), "stall rose without an input")
  // After two results in a row the back end has not yet made its next result.
  `HCR_ASSERT_NEXT(a_out_spacing, out_acc ##1 out_acc, !out_valid, "results too close together")

endmodule

bind hermite_cubic_resampler_top hcr_checker u_hcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
